@@ hdl/aldk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldk_pkg
// Shared types and constants for the ADC ladder keypad decoder/debouncer.
// ----------------------------------------------------------------------------
package aldk_pkg;

  localparam int SAMPLE_W = 16;
  localparam int KEY_W    = 3;
  localparam int NUM_KEYS = 4;
  localparam int COUNT_W  = 2;
  localparam int REG_IDX_W = 3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [KEY_W-1:0]    key_t;

  localparam key_t KEY_NONE = 3'd0;
  localparam key_t KEY_S1   = 3'd1;
  localparam key_t KEY_S2   = 3'd2;
  localparam key_t KEY_S3   = 3'd3;
  localparam key_t KEY_S4   = 3'd4;

  // operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_S1_MAX  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_S2_LOW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_S2_HIGH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_S3_LOW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_S3_HIGH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_S4_LOW  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_S4_HIGH = 3'd6;

  localparam sample_t RST_S1_MAX  = 16'd200;
  localparam sample_t RST_S2_LOW  = 16'd17000;
  localparam sample_t RST_S2_HIGH = 16'd20000;
  localparam sample_t RST_S3_LOW  = 16'd28000;
  localparam sample_t RST_S3_HIGH = 16'd31000;
  localparam sample_t RST_S4_LOW  = 16'd46000;
  localparam sample_t RST_S4_HIGH = 16'd50000;

  typedef struct packed {
    sample_t s1_max;
    sample_t s2_low;
    sample_t s2_high;
    sample_t s3_low;
    sample_t s3_high;
    sample_t s4_low;
    sample_t s4_high;
  } win_cfg_t;

  typedef struct packed {
    key_t                decoded_key;
    key_t                pressed_key;
    logic                any_pressed;
    logic [NUM_KEYS-1:0] pending_events;
    logic                consumed_event;
  } result_t;

endpackage

@@ hdl/aldk_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldk_classify
// Window compare of one ADC sample against the four key windows, S1 first.
// ----------------------------------------------------------------------------
module aldk_classify (
  input  aldk_pkg::sample_t  sample,
  input  aldk_pkg::win_cfg_t win,
  output aldk_pkg::key_t     key
);
  import aldk_pkg::*;

  always_comb begin
    if (sample <= win.s1_max) begin
      key = KEY_S1;
    end else if (sample >= win.s2_low && sample <= win.s2_high) begin
      key = KEY_S2;
    end else if (sample >= win.s3_low && sample <= win.s3_high) begin
      key = KEY_S3;
    end else if (sample >= win.s4_low && sample <= win.s4_high) begin
      key = KEY_S4;
    end else begin
      key = KEY_NONE;
    end
  end

endmodule

@@ hdl/aldk_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldk_core
// Debounce state, confirmed key and sticky event flags; builds one result.
// ----------------------------------------------------------------------------
module aldk_core #(
  parameter int CONFIRM_CAP = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  op,
  input  aldk_pkg::key_t        key,
  input  logic [1:0]            consume_key,
  output aldk_pkg::result_t     result
);
  import aldk_pkg::*;

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CONFIRM_CAP);

  key_t                candidate_key, candidate_key_next;
  logic [COUNT_W-1:0]  confirm_count, confirm_count_next;
  key_t                last_key, last_key_next;
  logic [NUM_KEYS-1:0] event_flags, event_flags_next;
  logic                consumed;

  always_comb begin
    candidate_key_next = candidate_key;
    confirm_count_next = confirm_count;
    last_key_next      = last_key;
    event_flags_next   = event_flags;
    consumed           = 1'b0;
    if (op == OP_SAMPLE) begin
      if (key != candidate_key) begin
        candidate_key_next = key;
        confirm_count_next = '0;
      end else begin
        if (confirm_count < CAP) begin
          confirm_count_next = confirm_count + 1'b1;
        end
        if (confirm_count_next != '0 && key != last_key) begin
          last_key_next = key;
          if (key != KEY_NONE) begin
            event_flags_next[2'(key - 1'b1)] = 1'b1;
          end
        end
      end
    end else begin
      consumed                      = event_flags[consume_key];
      event_flags_next[consume_key] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_key <= KEY_NONE;
      confirm_count <= '0;
      last_key      <= KEY_NONE;
      event_flags   <= '0;
    end else if (step) begin
      candidate_key <= candidate_key_next;
      confirm_count <= confirm_count_next;
      last_key      <= last_key_next;
      event_flags   <= event_flags_next;
    end
  end

  always_comb begin
    result.decoded_key    = (op == OP_SAMPLE) ? key : KEY_NONE;
    result.pressed_key    = last_key_next;
    result.any_pressed    = (last_key_next != KEY_NONE);
    result.pending_events = event_flags_next;
    result.consumed_event = consumed;
  end

endmodule

@@ hdl/adc_ladder_key_debounce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_ladder_key_debounce
// Resistor-ladder keypad decoder with debounce and sticky key events.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. An item passes an input
// register, then window decode and debounce update combinationally into the
// result register; one item per cycle is sustained while the output is not
// stalled. The input register holds one more item while a result waits.
// A key is confirmed after it is seen on two consecutive samples
// (CONFIRM_CAP sets the saturating count, 1 to 3). Configuration writes
// take effect on the next cycle and are meant to happen while idle.
// ----------------------------------------------------------------------------
module adc_ladder_key_debounce #(
  parameter int CONFIRM_CAP = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [aldk_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [aldk_pkg::SAMPLE_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic [aldk_pkg::SAMPLE_W-1:0]      raw_sample,
  input  logic [1:0]                         consume_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [aldk_pkg::KEY_W-1:0]         decoded_key,
  output logic [aldk_pkg::KEY_W-1:0]         pressed_key,
  output logic                               any_pressed,
  output logic [aldk_pkg::NUM_KEYS-1:0]      pending_events,
  output logic                               consumed_event
);
  import aldk_pkg::*;

  win_cfg_t win;

  logic       in_q_valid;
  logic       in_q_op;
  sample_t    in_q_sample;
  logic [1:0] in_q_key;

  logic    advance;
  logic    in_take;
  key_t    cls_key;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.s1_max  <= RST_S1_MAX;
      win.s2_low  <= RST_S2_LOW;
      win.s2_high <= RST_S2_HIGH;
      win.s3_low  <= RST_S3_LOW;
      win.s3_high <= RST_S3_HIGH;
      win.s4_low  <= RST_S4_LOW;
      win.s4_high <= RST_S4_HIGH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_S1_MAX:  win.s1_max  <= cfg_data;
        REG_S2_LOW:  win.s2_low  <= cfg_data;
        REG_S2_HIGH: win.s2_high <= cfg_data;
        REG_S3_LOW:  win.s3_low  <= cfg_data;
        REG_S3_HIGH: win.s3_high <= cfg_data;
        REG_S4_LOW:  win.s4_low  <= cfg_data;
        REG_S4_HIGH: win.s4_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage moves when the result register is empty or being drained
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_op     <= op;
      in_q_sample <= raw_sample;
      in_q_key    <= consume_key;
    end
  end

  aldk_classify u_classify (
    .sample (in_q_sample),
    .win    (win),
    .key    (cls_key)
  );

  aldk_core #(
    .CONFIRM_CAP (CONFIRM_CAP)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .op          (in_q_op),
    .key         (cls_key),
    .consume_key (in_q_key),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      decoded_key    <= result.decoded_key;
      pressed_key    <= result.pressed_key;
      any_pressed    <= result.any_pressed;
      pending_events <= result.pending_events;
      consumed_event <= result.consumed_event;
    end
  end

endmodule
